>>> hdl/led_driver_serial_frame_sender_macros.svh
// assertion macros for the port-level checker file
`ifndef LED_DRIVER_SERIAL_FRAME_SENDER_MACROS_SVH
`define LED_DRIVER_SERIAL_FRAME_SENDER_MACROS_SVH

// same-cycle implication, disabled during reset
`define LEDSS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// next-cycle implication, disabled during reset
`define LEDSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

>>> hdl/ledss_pkg.sv
// shared types and constants for the led serial frame sender
`default_nettype none

package ledss_pkg;

  // number of buffer bytes sent in the address transaction
  localparam int NUM_DIGITS = 16;
  localparam int BUF_DEPTH  = 16;
  localparam int IDX_W      = 4;
  localparam int BYTE_CNT_W = 5;

  // operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // command bytes
  localparam logic [7:0] CMD_DATA = 8'h40;
  localparam logic [7:0] CMD_ADDR = 8'hC0;
  localparam logic [7:0] DISPLAY_CONTROL_RESET = 8'h8C;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] byte_index;
    logic [7:0] byte_value;
  } ledss_item_t;

  typedef struct packed {
    logic refresh_done;
    logic busy_res;
    logic data_line;
    logic clock_line;
  } ledss_result_t;

endpackage

`default_nettype wire

>>> hdl/ledss_engine.sv
// pin event sequencer with segment buffer and display-control register
`default_nettype none

module ledss_engine
  import ledss_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_accept,
  input  wire ledss_item_t   item,
  input  wire logic          cfg_we,
  input  wire logic [7:0]    cfg_data,
  output ledss_result_t      result
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_BYTE  = 2'd2;
  localparam logic [1:0] PH_STOP  = 2'd3;

  logic [1:0]            phase, phase_next;
  logic [2:0]            sub_step, sub_step_next;
  logic [3:0]            bit_counter, bit_counter_next;
  logic [7:0]            shift_byte, shift_byte_next;
  logic [BYTE_CNT_W-1:0] byte_counter, byte_counter_next;
  logic [1:0]            transaction, transaction_next;
  logic                  clk_pin, clk_pin_next;
  logic                  dat_pin, dat_pin_next;
  logic [7:0]            display_control;
  logic [7:0]            segment_buffer [BUF_DEPTH];
  logic                  busy;
  logic                  buf_we;
  logic                  done;
  logic                  busy_out;

  assign busy = (phase != PH_IDLE);

  // next state for one item
  always_comb begin
    phase_next        = phase;
    sub_step_next     = sub_step;
    bit_counter_next  = bit_counter;
    shift_byte_next   = shift_byte;
    byte_counter_next = byte_counter;
    transaction_next  = transaction;
    clk_pin_next      = clk_pin;
    dat_pin_next      = dat_pin;
    buf_we            = 1'b0;
    done              = 1'b0;
    busy_out          = busy;
    if (item_accept) begin
      case (item.operation)
        OP_LOAD: begin
          buf_we = !busy;
        end
        OP_START: begin
          if (!busy) begin
            transaction_next  = 2'd0;
            byte_counter_next = '0;
            bit_counter_next  = 4'd0;
            sub_step_next     = 3'd0;
            phase_next        = PH_START;
            busy_out          = 1'b1;
          end
        end
        OP_TICK: begin
          case (phase)
            PH_START: begin
              case (sub_step)
                3'd0: dat_pin_next = 1'b1;
                3'd1: clk_pin_next = 1'b1;
                3'd2: dat_pin_next = 1'b1;
                3'd3: dat_pin_next = 1'b0;
                default: clk_pin_next = 1'b0;
              endcase
              if (sub_step >= 3'd4) begin
                bit_counter_next = 4'd0;
                sub_step_next    = 3'd0;
                phase_next       = PH_BYTE;
                if (transaction == 2'd0) begin
                  shift_byte_next = CMD_DATA;
                end else if (transaction == 2'd1) begin
                  shift_byte_next   = CMD_ADDR;
                  byte_counter_next = '0;
                end else begin
                  shift_byte_next = display_control;
                end
              end else begin
                sub_step_next = sub_step + 3'd1;
              end
            end
            PH_BYTE: begin
              if (bit_counter < 4'd8) begin
                if (sub_step == 3'd0) begin
                  clk_pin_next  = 1'b0;
                  sub_step_next = 3'd1;
                end else if (sub_step == 3'd1) begin
                  dat_pin_next  = shift_byte[0];
                  sub_step_next = 3'd2;
                end else begin
                  clk_pin_next     = 1'b1;
                  shift_byte_next  = {1'b0, shift_byte[7:1]};
                  bit_counter_next = bit_counter + 4'd1;
                  sub_step_next    = 3'd0;
                end
              end else begin
                if (sub_step == 3'd0) begin
                  clk_pin_next  = 1'b0;
                  sub_step_next = 3'd1;
                end else begin
                  dat_pin_next  = 1'b0;
                  sub_step_next = 3'd0;
                  if (transaction == 2'd1 &&
                      byte_counter < BYTE_CNT_W'(NUM_DIGITS)) begin
                    // next buffer byte of the address transaction
                    shift_byte_next   = segment_buffer[byte_counter[IDX_W-1:0]];
                    byte_counter_next = byte_counter + BYTE_CNT_W'(1);
                    bit_counter_next  = 4'd0;
                  end else begin
                    phase_next = PH_STOP;
                  end
                end
              end
            end
            PH_STOP: begin
              case (sub_step)
                3'd0: clk_pin_next = 1'b1;
                3'd1: dat_pin_next = 1'b0;
                3'd2: dat_pin_next = 1'b1;
                3'd3: clk_pin_next = 1'b0;
                default: dat_pin_next = 1'b0;
              endcase
              if (sub_step >= 3'd4) begin
                sub_step_next = 3'd0;
                if (transaction < 2'd2) begin
                  transaction_next = transaction + 2'd1;
                  phase_next       = PH_START;
                end else begin
                  transaction_next = 2'd0;
                  phase_next       = PH_IDLE;
                  done             = 1'b1;
                end
              end else begin
                sub_step_next = sub_step + 3'd1;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // result reflects levels after this item
  always_comb begin
    result.clock_line   = clk_pin_next;
    result.data_line    = dat_pin_next;
    result.busy_res     = busy_out;
    result.refresh_done = done;
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      sub_step     <= 3'd0;
      bit_counter  <= 4'd0;
      shift_byte   <= 8'd0;
      byte_counter <= '0;
      transaction  <= 2'd0;
      clk_pin      <= 1'b0;
      dat_pin      <= 1'b0;
    end else begin
      phase        <= phase_next;
      sub_step     <= sub_step_next;
      bit_counter  <= bit_counter_next;
      shift_byte   <= shift_byte_next;
      byte_counter <= byte_counter_next;
      transaction  <= transaction_next;
      clk_pin      <= clk_pin_next;
      dat_pin      <= dat_pin_next;
    end
  end

  // display-control register
  always_ff @(posedge clk) begin
    if (rst) begin
      display_control <= DISPLAY_CONTROL_RESET;
    end else if (cfg_we) begin
      display_control <= cfg_data;
    end
  end

  // segment buffer, blank after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BUF_DEPTH; i++) begin
        segment_buffer[i] <= 8'd0;
      end
    end else if (buf_we) begin
      segment_buffer[item.byte_index] <= item.byte_value;
    end
  end

endmodule

`default_nettype wire

>>> hdl/led_driver_serial_frame_sender.sv
// Two-wire LED display frame sender. Every input word yields one result word,
// so the block sustains one word per clock while tready is high; the rate is
// set by the per-word pin event sequencer in ledss_engine. Load words fill
// the 16-byte segment buffer while idle, a start word begins a refresh, and
// each tick word moves the pins by one event (a full refresh is 524 ticks).
// Results pass through a two-entry output buffer, so input is still taken while
// one result waits; tready falls only when both entries are held.
`default_nettype none

module led_driver_serial_frame_sender
  import ledss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // byte_index[3:0], byte_value[11:4], zero
  input  wire logic [1:0]  s_axis_tuser,   // operation[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // clock_line[0], data_line[1], busy_res[2], zero
  output logic             m_axis_tlast,   // refresh_done
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  ledss_item_t   item;
  ledss_result_t res_new;
  ledss_result_t out_res;
  ledss_result_t skid_res;
  logic          out_valid;
  logic          skid_valid;
  logic          accept;
  logic          pop;

  assign item.operation  = s_axis_tuser;
  assign item.byte_index = s_axis_tdata[3:0];
  assign item.byte_value = s_axis_tdata[11:4];

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = out_valid && m_axis_tready;
  assign cfg_ready     = 1'b1;

  ledss_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .item_accept (accept),
    .item        (item),
    .cfg_we      (cfg_valid),
    .cfg_data    (cfg_data),
    .result      (res_new)
  );

  // two-entry output buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // buffer payload
  always_ff @(posedge clk) begin
    if (pop || !out_valid) begin
      out_res <= skid_valid ? skid_res : res_new;
    end else if (accept) begin
      skid_res <= res_new;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_res.busy_res, out_res.data_line, out_res.clock_line};
  assign m_axis_tlast  = out_res.refresh_done;

endmodule

`default_nettype wire

>>> hdl/ledss_checker.sv
// port-level checks for the led serial frame sender, bound to the top level
`default_nettype none
`include "led_driver_serial_frame_sender_macros.svh"

module ledss_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic        m_axis_tlast
);

  // a stalled result word holds
  `LEDSS_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // with no result pending the buffer has room
  `LEDSS_ASSERT_NOW(a_ready_when_empty, clk, rst, !m_axis_tvalid, s_axis_tready)

  // final pin event is still reported busy
  `LEDSS_ASSERT_NOW(a_done_busy, clk, rst, m_axis_tvalid && m_axis_tlast, m_axis_tdata[2])

  // a refresh ends with both pins low
  `LEDSS_ASSERT_NOW(a_done_pins_low, clk, rst, m_axis_tvalid && m_axis_tlast, !m_axis_tdata[0] && !m_axis_tdata[1])

endmodule

bind led_driver_serial_frame_sender ledss_checker u_ledss_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

>>> bench/led_driver_serial_frame_sender_test.sv
// self-checking stream testbench for the two-wire led display frame sender
`timescale 1ns / 100ps

module led_driver_serial_frame_sender_test;
  import ledss_pkg::*;

  // operation code with no effect on the block
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_TARGET  = 1400;
  localparam int STALL_CYCLES = 300;
  localparam int LIMIT_CYCLES = 400000;

  typedef enum logic [1:0] {PH_IDLE, PH_START, PH_BYTE, PH_STOP} frame_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // byte_index[3:0], byte_value[11:4], zero
  logic [1:0]  s_axis_tuser = '0;   // operation[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // clock_line[0], data_line[1], busy_res[2], zero
  logic        m_axis_tlast;        // refresh_done
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  led_driver_serial_frame_sender dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  // shadow copy of the sequencer state
  logic [7:0]   seg_mem [BUF_DEPTH];
  frame_phase_t phase;
  logic [4:0]   byte_cnt;
  logic [3:0]   bit_cnt;
  logic [7:0]   shift_reg;
  logic         pin_clk;
  logic         pin_dat;
  logic [2:0]   sub_cnt;
  logic [1:0]   xfer_num;
  logic [7:0]   ctrl_byte;

  ledss_result_t pin_expect_q [$];
  int  items_sent = 0;
  int  results_seen = 0;
  int  frames_predicted = 0;
  int  ctrl_writes = 0;
  int  fail_count = 0;
  bit  no_gaps = 1'b0;
  int  stall_req_cnt = 0;
  int  stall_seen = 0;
  int  stall_left = 0;
  int  sink_gap = 0;

  function automatic void load_next_byte(input logic [7:0] v);
    shift_reg = v;
    bit_cnt   = '0;
    sub_cnt   = '0;
    phase     = PH_BYTE;
  endfunction

  // one pin event; returns 1 on the last event of a refresh
  function automatic logic advance_pins();
    logic       fin;
    logic [7:0] v;
    fin = 1'b0;
    case (phase)
      PH_START: begin
        case (sub_cnt)
          3'd0: pin_dat = 1'b1;
          3'd1: pin_clk = 1'b1;
          3'd2: pin_dat = 1'b1;
          3'd3: pin_dat = 1'b0;
          default: pin_clk = 1'b0;
        endcase
        if (sub_cnt >= 3'd4) begin
          if (xfer_num == 2'd0) begin
            load_next_byte(CMD_DATA);
          end else if (xfer_num == 2'd1) begin
            byte_cnt = '0;
            load_next_byte(CMD_ADDR);
          end else begin
            load_next_byte(ctrl_byte);
          end
        end else begin
          sub_cnt++;
        end
      end
      PH_BYTE: begin
        if (bit_cnt < 4'd8) begin
          if (sub_cnt == 3'd0) begin
            pin_clk = 1'b0;
            sub_cnt = 3'd1;
          end else if (sub_cnt == 3'd1) begin
            pin_dat = shift_reg[0];
            sub_cnt = 3'd2;
          end else begin
            pin_clk   = 1'b1;
            shift_reg = shift_reg >> 1;
            bit_cnt++;
            sub_cnt   = 3'd0;
          end
        end else if (sub_cnt == 3'd0) begin
          pin_clk = 1'b0;
          sub_cnt = 3'd1;
        end else begin
          pin_dat = 1'b0;
          // address transaction streams the whole buffer
          if (xfer_num == 2'd1 && byte_cnt < NUM_DIGITS) begin
            v = seg_mem[byte_cnt[3:0]];
            byte_cnt++;
            load_next_byte(v);
          end else begin
            phase   = PH_STOP;
            sub_cnt = 3'd0;
          end
        end
      end
      PH_STOP: begin
        case (sub_cnt)
          3'd0: pin_clk = 1'b1;
          3'd1: pin_dat = 1'b0;
          3'd2: pin_dat = 1'b1;
          3'd3: pin_clk = 1'b0;
          default: pin_dat = 1'b0;
        endcase
        if (sub_cnt >= 3'd4) begin
          sub_cnt = 3'd0;
          if (xfer_num < 2'd2) begin
            xfer_num++;
            phase = PH_START;
          end else begin
            xfer_num = 2'd0;
            phase    = PH_IDLE;
            fin      = 1'b1;
          end
        end else begin
          sub_cnt++;
        end
      end
      default: ;
    endcase
    return fin;
  endfunction

  // expected result word for one accepted input word
  function automatic ledss_result_t predict_pins(input logic [1:0] op, input logic [3:0] idx,
                                                 input logic [7:0] val);
    ledss_result_t r;
    logic busy;
    logic fin;
    busy = (phase != PH_IDLE);
    fin  = 1'b0;
    r.busy_res = busy;
    case (op)
      OP_LOAD: begin
        if (!busy) seg_mem[idx] = val;
      end
      OP_START: begin
        if (!busy) begin
          xfer_num   = 2'd0;
          byte_cnt   = '0;
          bit_cnt    = '0;
          sub_cnt    = '0;
          phase      = PH_START;
          r.busy_res = 1'b1;
        end
      end
      OP_TICK: begin
        if (busy) fin = advance_pins();
      end
      default: ;
    endcase
    r.clock_line   = pin_clk;
    r.data_line    = pin_dat;
    r.refresh_done = fin;
    if (fin) frames_predicted++;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    fail_count++;
  endtask

  // send one word, sometimes with a random gap before it
  task automatic send_item(input logic [1:0] op, input logic [3:0] idx, input logic [7:0] val);
    ledss_result_t want;
    @(negedge clk);
    if (!no_gaps && $urandom_range(99) < 14) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0000, val, idx};
    do @(posedge clk); while (!s_axis_tready);
    want = predict_pins(op, idx, val);
    pin_expect_q.push_back(want);
    items_sent++;
  endtask

  // stop offering and wait until every result has come back
  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait (pin_expect_q.size() == 0);
  endtask

  task automatic write_control(input logic [7:0] v);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    ctrl_byte = v;
    ctrl_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stray word: ignored ops while busy, harmless ops while idle
  task automatic send_noise(input bit during_refresh);
    logic [1:0] op;
    case ($urandom_range(2))
      0: op = during_refresh ? OP_LOAD : OP_TICK;
      1: op = during_refresh ? OP_START : OP_UNUSED;
      default: op = OP_UNUSED;
    endcase
    send_item(op, 4'($urandom_range(15)), 8'($urandom_range(255)));
  endtask

  task automatic fill_buffer(input int count, input bit whole);
    int i;
    if (whole) begin
      for (i = 0; i < BUF_DEPTH; i++) send_item(OP_LOAD, 4'(i), 8'($urandom_range(255)));
    end
    for (i = 0; i < count; i++) begin
      if ($urandom_range(99) < 8) send_noise(1'b0);
      else send_item(OP_LOAD, 4'($urandom_range(15)), 8'($urandom_range(255)));
    end
  endtask

  // one refresh with stray words mixed in; optional sink stall or source pause
  task automatic refresh_with_noise(input int noise_pct, input int stall_at, input int pause_at);
    int n;
    n = 0;
    send_item(OP_START, 4'($urandom_range(15)), 8'($urandom_range(255)));
    while (phase != PH_IDLE) begin
      if (n == stall_at) stall_req_cnt++;
      if (n == pause_at) drain_results();
      if ($urandom_range(99) < noise_pct) send_noise(1'b1);
      else send_item(OP_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)));
      n++;
    end
  endtask

  task automatic test_directed_cases();
    send_item(OP_TICK, 4'h0, 8'h00);     // tick while idle holds the pins
    send_item(OP_UNUSED, 4'hF, 8'hFF);   // unused code reports levels only
    send_item(OP_LOAD, 4'h0, 8'h00);
    send_item(OP_LOAD, 4'hF, 8'hFF);
    send_item(OP_LOAD, 4'h7, 8'h5A);
    send_item(OP_LOAD, 4'h8, 8'hA5);
    send_item(OP_LOAD, 4'h0, 8'h81);     // overwrite a position
    send_item(OP_START, 4'h3, 8'h3C);
    repeat (3) send_item(OP_TICK, 4'hA, 8'h55);
    send_item(OP_LOAD, 4'hF, 8'h00);     // load while busy is dropped
    send_item(OP_START, 4'h0, 8'h00);    // start while busy is dropped
    send_item(OP_UNUSED, 4'h5, 8'h0F);
    while (phase != PH_IDLE) send_item(OP_TICK, 4'h0, 8'h00);
    send_item(OP_TICK, 4'hF, 8'hFF);
    send_item(OP_UNUSED, 4'h0, 8'h00);
  endtask

  task automatic test_control_extremes();
    // all-zero control with a long sink stall mid frame
    write_control(8'h00);
    fill_buffer(6, 1'b1);
    refresh_with_noise(6, 150, -1);
  endtask

  task automatic test_random_traffic();
    int round;
    round = 0;
    do begin
      drain_results();
      if (round == 0) begin
        // all-ones control, back to back words on both sides, source pause mid frame
        write_control(8'hFF);
        no_gaps = 1'b1;
        fill_buffer(10, 1'b0);
        refresh_with_noise(4, -1, 260);
        no_gaps = 1'b0;
      end else begin
        if ($urandom_range(1)) write_control(8'($urandom_range(255)));
        else write_control(DISPLAY_CONTROL_RESET);
        fill_buffer(int'($urandom_range(30, 2)), 1'($urandom_range(1)));
        refresh_with_noise(int'($urandom_range(15)), -1, -1);
      end
      round++;
    end while (items_sent < ITEM_TARGET);
  endtask

  // sink pacing, with a long hold-off on request
  always @(negedge clk) begin : sink_pacing
    if (stall_req_cnt != stall_seen) begin
      stall_seen    <= stall_req_cnt;
      stall_left    <= STALL_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (no_gaps) begin
      m_axis_tready <= 1'b1;
    end else if (sink_gap > 0) begin
      sink_gap      <= sink_gap - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(99) < 14) begin
      sink_gap      <= int'($urandom_range(3));
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // compare each result word with the oldest expectation
  initial begin : result_check
    ledss_result_t got;
    ledss_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        got.clock_line   = m_axis_tdata[0];
        got.data_line    = m_axis_tdata[1];
        got.busy_res     = m_axis_tdata[2];
        got.refresh_done = m_axis_tlast;
        if (pin_expect_q.size() == 0) begin
          report_mismatch("unexpected result word", int'(got), 0);
        end else begin
          want = pin_expect_q.pop_front();
          if (got.clock_line !== want.clock_line)
            report_mismatch("clock_line", int'(got.clock_line), int'(want.clock_line));
          if (got.data_line !== want.data_line)
            report_mismatch("data_line", int'(got.data_line), int'(want.data_line));
          if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", int'(got.busy_res), int'(want.busy_res));
          if (got.refresh_done !== want.refresh_done)
            report_mismatch("refresh_done", int'(got.refresh_done), int'(want.refresh_done));
        end
        results_seen++;
      end
    end
  end

  // watchdog
  initial begin : run_limit
    #(LIMIT_CYCLES * 20);
    $display("led_driver_serial_frame_sender regression: fail");
    $finish;
  end

  initial begin : test_sequence
    int i;
    for (i = 0; i < BUF_DEPTH; i++) seg_mem[i] = 8'h00;
    phase     = PH_IDLE;
    byte_cnt  = '0;
    bit_cnt   = '0;
    shift_reg = '0;
    pin_clk   = 1'b0;
    pin_dat   = 1'b0;
    sub_cnt   = '0;
    xfer_num  = '0;
    ctrl_byte = DISPLAY_CONTROL_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_control_extremes();
    test_random_traffic();

    drain_results();
    repeat (10) @(posedge clk);
    if (pin_expect_q.size() != 0) report_mismatch("results never arrived", 0, pin_expect_q.size());

    $display("covered %0d words in, %0d results out, %0d complete refreshes",
             items_sent, results_seen, frames_predicted);
    $display("control byte written %0d times, incl. all-zero and all-ones, with stalls",
             ctrl_writes);
    if (fail_count == 0) begin
      $display("led_driver_serial_frame_sender regression: pass");
    end else begin
      $display("led_driver_serial_frame_sender regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/ledss_pkg.sv
hdl/ledss_engine.sv
hdl/led_driver_serial_frame_sender.sv
hdl/ledss_checker.sv
bench/led_driver_serial_frame_sender_test.sv
